// File: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sha1_pkg;

  // Depth of the operation queue between the front and the back.
  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);

  localparam logic [4:0][31:0] SHA1_IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_BYTE_FIN,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAD,
    BK_ROUND,
    BK_ADD,
    BK_OUT
  } bk_state_e;

endpackage

`default_nettype wire

// File: hdl/sha1_front.sv
// Front end: takes input transactions, classifies them and holds one operation.
// Depends on sha1_pkg.
`default_nettype none

module sha1_front import sha1_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data_i,
  output logic          enq_o,
  output op_t           enq_op_o,
  input  wire logic     q_full_i
);

  logic fr_valid_q, fr_valid_d;
  op_t  fr_op_q, fr_op_d;
  logic accept, keep;
  op_t  cls_op;

  // items with neither a byte nor the last flag do nothing and are dropped
  assign keep = in_data_i.byte_present | in_data_i.last_byte;

  always_comb begin
    cls_op.data = in_data_i.message_byte;
    if (!in_data_i.last_byte) begin
      cls_op.kind = OP_BYTE;
    end else if (in_data_i.byte_present) begin
      cls_op.kind = OP_BYTE_FIN;
    end else begin
      cls_op.kind = OP_FIN;
    end
  end

  assign full     = fr_valid_q & q_full_i;
  assign accept   = push & ~full;
  assign enq_o    = fr_valid_q & ~q_full_i;
  assign enq_op_o = fr_op_q;

  always_comb begin
    fr_op_d    = fr_op_q;
    fr_valid_d = fr_valid_q & q_full_i;
    if (accept) begin
      fr_valid_d = keep;
      fr_op_d    = cls_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_op_q <= fr_op_d;
  end

endmodule

`default_nettype wire

// File: hdl/sha1_opq.sv
// Short operation queue between the front and the back end.
// Depends on sha1_pkg.
`default_nettype none

module sha1_opq import sha1_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  output logic      valid_o,
  output op_t       op_o,
  input  wire logic pop_i
);

  op_t                mem_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OPQ_AW:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (OPQ_AW+1)'(OPQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sha1_back.sv
// Back end: byte packing, padding, 80-round compression and digest output.
// Depends on sha1_pkg.
`default_nettype none

module sha1_back import sha1_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire op_t   q_op_i,
  output logic       q_pop_o,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_data_o
);

  bk_state_e        state_q, state_d;
  logic [4:0][31:0] cv_q, cv_d;
  logic [4:0][31:0] wv_q, wv_d;
  logic [15:0][31:0] win_q, win_d;
  logic [63:0]      bit_len_q, bit_len_d;
  logic [5:0]       pos_q, pos_d;
  logic [6:0]       round_q, round_d;
  logic [2:0]       out_idx_q, out_idx_d;
  logic             fin_q, fin_d, pad80_q, pad80_d, len_q, len_d;

  logic        wr_en;
  logic [7:0]  wr_byte, len_byte;
  logic        len_now, take_op, out_done;
  logic [31:0] f_val, k_val, tmp, w_new;
  logic [31:0] b, c, d;

  assign take_op  = (state_q == BK_IDLE) && q_valid_i;
  assign q_pop_o  = take_op;
  assign len_now  = len_q || (pos_q == LEN_POS);
  assign len_byte = bit_len_q[{~pos_q[2:0], 3'b000} +: 8];
  assign out_done = (state_q == BK_OUT) && pop && (out_idx_q == LAST_WORD_IDX);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          case (q_op_i.kind)
            OP_BYTE:     state_d = (pos_q == LAST_POS) ? BK_ROUND : BK_IDLE;
            OP_BYTE_FIN: state_d = (pos_q == LAST_POS) ? BK_ROUND : BK_PAD;
            OP_FIN:      state_d = BK_PAD;
            default:     state_d = BK_IDLE;
          endcase
        end
      end
      BK_PAD: begin
        if (pos_q == LAST_POS) begin
          state_d = BK_ROUND;
        end
      end
      BK_ROUND: begin
        if (round_q == LAST_ROUND) begin
          state_d = BK_ADD;
        end
      end
      BK_ADD: begin
        if (!fin_q) begin
          state_d = BK_IDLE;
        end else if (len_q) begin
          state_d = BK_OUT;
        end else begin
          state_d = BK_PAD;
        end
      end
      BK_OUT: begin
        if (out_done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // round function
  assign b = wv_q[1];
  assign c = wv_q[2];
  assign d = wv_q[3];

  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = K_R0;
    end else if (round_q < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = K_R1;
    end else if (round_q < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K_R2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K_R3;
    end
  end

  assign tmp   = {wv_q[0][26:0], wv_q[0][31:27]} + f_val + wv_q[4] + k_val + win_q[0];
  assign w_new = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  // outputs and datapath
  always_comb begin
    wr_en     = 1'b0;
    wr_byte   = '0;
    cv_d      = cv_q;
    wv_d      = wv_q;
    win_d     = win_q;
    bit_len_d = bit_len_q;
    pos_d     = pos_q;
    round_d   = round_q;
    out_idx_d = out_idx_q;
    fin_d     = fin_q;
    pad80_d   = pad80_q;
    len_d     = len_q;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_op_i.kind != OP_BYTE) begin
            fin_d   = 1'b1;
            pad80_d = 1'b0;
            len_d   = 1'b0;
          end
          if (q_op_i.kind != OP_FIN) begin
            wr_en     = 1'b1;
            wr_byte   = q_op_i.data;
            bit_len_d = bit_len_q + 64'd8;
          end
        end
      end
      BK_PAD: begin
        wr_en = 1'b1;
        if (!pad80_q) begin
          wr_byte = PAD_BYTE;
          pad80_d = 1'b1;
        end else if (len_now) begin
          wr_byte = len_byte;
          len_d   = 1'b1;
        end else begin
          wr_byte = '0;
        end
      end
      BK_ROUND: begin
        wv_d[4] = d;
        wv_d[3] = c;
        wv_d[2] = {b[1:0], b[31:2]};
        wv_d[1] = wv_q[0];
        wv_d[0] = tmp;
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = {w_new[30:0], w_new[31]};
        round_d   = round_q + 1'b1;
      end
      BK_ADD: begin
        for (int i = 0; i < 5; i++) begin
          cv_d[i] = cv_q[i] + wv_q[i];
        end
      end
      BK_OUT: begin
        if (pop) begin
          out_idx_d = out_idx_q + 1'b1;
          if (out_idx_q == LAST_WORD_IDX) begin
            out_idx_d = '0;
            cv_d      = SHA1_IV;
            bit_len_d = '0;
            pos_d     = '0;
            fin_d     = 1'b0;
            len_d     = 1'b0;
          end
        end
      end
      default: ;
    endcase

    if (wr_en) begin
      win_d[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] = wr_byte;
      pos_d = pos_q + 1'b1;
      if (pos_q == LAST_POS) begin
        // block complete: load working variables for the first round
        wv_d    = cv_q;
        round_d = '0;
      end
    end
  end

  assign empty                  = (state_q != BK_OUT);
  assign out_data_o.digest_word = cv_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == LAST_WORD_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cv_q      <= SHA1_IV;
      bit_len_q <= '0;
      pos_q     <= '0;
      round_q   <= '0;
      out_idx_q <= '0;
      fin_q     <= 1'b0;
      pad80_q   <= 1'b0;
      len_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cv_q      <= cv_d;
      bit_len_q <= bit_len_d;
      pos_q     <= pos_d;
      round_q   <= round_d;
      out_idx_q <= out_idx_d;
      fin_q     <= fin_d;
      pad80_q   <= pad80_d;
      len_q     <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    win_q <= win_d;
  end

`ifndef SYNTHESIS
  a_out_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT) |-> (out_idx_q <= LAST_WORD_IDX))
    else $error("digest word index out of range");

  a_round_start_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROUND && round_q == '0) |-> (pos_q == '0))
    else $error("compression started mid-block");

  a_last_round_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROUND && round_q == LAST_ROUND) |=> (state_q == BK_ADD))
    else $error("missing chaining add after last round");

  a_digest_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done |=> (state_q == BK_IDLE && bit_len_q == '0 && pos_q == '0 && cv_q == SHA1_IV))
    else $error("engine not restored after digest");
`endif

endmodule

`default_nettype wire

// File: hdl/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine: front end, operation queue, back end.
// Depends on sha1_pkg, sha1_front, sha1_opq and sha1_back.
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_data_i  (in_item_t)
//   result    out        empty / pop         out_data_o (out_item_t)
//
// The back end takes a message byte whenever it is idle; every 64th byte starts the
// compression, 80 rounds plus one chaining add, during which no byte is taken,
// so the byte rate is set by the one-round-per-cycle loop.
// Finishing pads one byte a cycle (9 to 72 bytes, up to two compressions),
// then the five digest words wait in the back end until popped.
// Reset (asynchronous, active low) restores the initial chaining values.
// The front register and the four-entry queue keep taking transactions, until the
// queue fills, while the back end compresses or holds a digest.
`default_nettype none

module sha1_hash_engine import sha1_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_data_o
);

  logic enq, q_full, q_valid, q_pop;
  op_t  enq_op, q_op;

  // classify and register incoming transactions
  sha1_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .enq_o     (enq),
    .enq_op_o  (enq_op),
    .q_full_i  (q_full)
  );

  // decouples the front from the long compression stalls
  sha1_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .op_i    (enq_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_op),
    .pop_i   (q_pop)
  );

  // packing, padding, compression and digest delivery
  sha1_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (q_op),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/sha1_hash_engine_test.sv
// Self-checking testbench for sha1_hash_engine: directed and random byte messages.
// Depends on sha1_pkg and the sha1_hash_engine RTL; needs nothing else.
`timescale 1ns / 100ps

module sha1_hash_engine_test;
  import sha1_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int MAX_IDLE     = 12;
  localparam int RANDOM_ITEMS = 230;
  localparam int MAX_REPORTS  = 10;
  // Finishing pads up to 72 bytes and runs up to two compressions; allow
  // a drain well beyond that before the verdict.
  localparam int DRAIN_CYCLES = 400;
  // Worst case is far below this: ~250 transactions with random idle gaps,
  // plus ~20 digests of five words under random pop stalls and padding.
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // Idle control: when set, that side runs back to back with no gaps.
  bit steady_sender;
  bit steady_receiver;

  int fault_count;
  int report_count;
  int cycle_count = 0;

  // Digest words predicted but not yet seen on the result side, oldest first.
  out_item_t expected_digest_words[$];

  // Predictor state: chaining values, 16-word block buffer / schedule window,
  // running bit count and byte position within the current block.
  logic [31:0] chain_words [5];
  logic [31:0] block_words [16];
  logic [63:0] message_bits;
  logic [5:0]  block_pos;

  sha1_hash_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost digest word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // SHA-1 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 5; i++) chain_words[i] = SHA1_IV[i];
    message_bits = '0;
    block_pos    = '0;
  endfunction

  // 80 rounds over block_words; the buffer is overwritten in place by the
  // rolling message schedule, exactly as the hardware reuses it.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, w, f, k, t;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = block_words[r];
      end else begin
        w = rotl32(block_words[(r - 3) % 16] ^ block_words[(r - 8) % 16] ^
                   block_words[(r - 14) % 16] ^ block_words[r % 16], 1);
        block_words[r % 16] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rotl32(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  // Big-endian packing; the first byte of a word clears the stale contents.
  function automatic void absorb_byte(input logic [7:0] data);
    logic [3:0] idx;
    int         shift;
    idx   = block_pos[5:2];
    shift = 24 - 8 * block_pos[1:0];
    if (block_pos[1:0] == 2'd0) block_words[idx] = 32'(data) << shift;
    else block_words[idx] = block_words[idx] | (32'(data) << shift);
    block_pos = block_pos + 6'd1;
    if (block_pos == 6'd0) compress_block();
  endfunction

  // One accepted input transaction: absorb the byte, and on the last flag pad,
  // finish and queue the five digest words.
  function automatic void predict_digest(input in_item_t item);
    logic [63:0] bit_count;
    out_item_t   word;
    if (item.byte_present) begin
      absorb_byte(item.message_byte);
      message_bits = message_bits + 64'd8;
    end
    if (!item.last_byte) return;
    bit_count = message_bits;
    absorb_byte(PAD_BYTE);
    while (block_pos != LEN_POS) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(bit_count[8 * i +: 8]);
    for (int i = 0; i < 5; i++) begin
      word.digest_word = chain_words[i];
      word.word_index  = 3'(i);
      word.last_word   = (3'(i) == LAST_WORD_IDX);
      expected_digest_words.push_back(word);
    end
    restart_hash();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Drives one transaction and returns once it has been accepted. push stays
  // high when the next transaction follows with no gap, so it is never
  // lowered and raised in the same time step.
  task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
    int       gap;
    in_item_t item;
    gap               = steady_sender ? 0 : $urandom_range(0, MAX_IDLE);
    item.message_byte = data;
    item.byte_present = present;
    item.last_byte    = fin;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_digest(item);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
  endtask

  // Always advances at least one edge, so a following push cannot land in
  // the same step as the release above.
  task automatic wait_results_drained();
    @(posedge clk_i);
    while (expected_digest_words.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, every accepted transaction checked
  // ---------------------------------------------------------------------------

  task automatic check_digest_word(input out_item_t got);
    out_item_t want;
    if (expected_digest_words.size() == 0) begin
      fault_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("unexpected digest word: word=%h index=%0d last=%0b",
                 got.digest_word, got.word_index, got.last_word);
      end
      return;
    end
    want = expected_digest_words.pop_front();
    if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
        got.last_word !== want.last_word) begin
      fault_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("digest mismatch: word exp %h got %h,", want.digest_word, got.digest_word,
                 " index exp %0d got %0d,", want.word_index, got.word_index,
                 " last exp %0b got %0b", want.last_word, got.last_word);
      end
    end
  endtask

  initial begin
    int stall;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // Occasionally flip between stalling and back-to-back popping.
      if ($urandom_range(0, 19) == 0) steady_receiver = !steady_receiver;
      stall = steady_receiver ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      check_digest_word(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Finish with no byte straight after reset, and again right after a digest:
  // both hash the empty message; the byte field must be ignored.
  task automatic test_empty_message();
    steady_sender = 1'b1;
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    stop_sending();
    wait_results_drained();
  endtask

  // "abc", then one-byte messages with the extreme byte values; the last
  // flag rides on the final byte.
  task automatic test_short_messages();
    steady_sender = 1'b0;
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    stop_sending();
    wait_results_drained();
  endtask

  // Bytes with ignored transactions in between, finished by a separate
  // no-byte last transaction.
  task automatic test_deferred_finish();
    steady_sender = 1'b0;
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);
    stop_sending();
    wait_results_drained();
  endtask

  // Random messages: mostly short, a quarter at the lengths around the
  // padding boundaries (55/56 bytes, one block and one byte short of it).
  // Ignored transactions are sprinkled in and do not count.
  task automatic test_random_messages();
    int msg_len;
    int sent;
    int msg_count;
    bit deferred;
    sent      = 0;
    msg_count = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       msg_len = 55;
          1:       msg_len = 56;
          2:       msg_len = 63;
          default: msg_len = 64;
        endcase
      end else begin
        msg_len = $urandom_range(0, 12);
      end
      deferred      = (msg_len == 0) || ($urandom_range(0, 3) == 0);
      steady_sender = ($urandom_range(0, 4) == 0);
      for (int j = 0; j < msg_len; j++) begin
        if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1, !deferred && (j == msg_len - 1));
        sent++;
      end
      if (deferred) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
      msg_count++;
      // Hold the sender once until every digest word has been popped.
      if (msg_count == 4) begin
        stop_sending();
        wait_results_drained();
      end
    end
    stop_sending();
  endtask

  initial begin
    fault_count     = 0;
    report_count    = 0;
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
    restart_hash();
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    in_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_short_messages();
    test_deferred_finish();
    test_random_messages();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && expected_digest_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
